// ===== rtl/core/btmp_pkg.sv =====
// btmp_pkg: shared types, constants and the melody tables for the buzzer tone player
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package btmp_pkg;

    // melody rom shape
    localparam int NOTES_PER_ROW = 8;
    localparam int MELODY_ROWS   = 15;

    // note-count divider widths: 8191 ms * 1000 needs 23 bits, 255*50+100 needs 14
    localparam int DIVIDEND_W = 23;
    localparam int DIVISOR_W  = 14;
    localparam int DIV_CNT_W  = 5;
    localparam int COUNT_W    = 16;

    // item function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_TONE   = 2'd1;
    localparam logic [1:0] FUNC_MELODY = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_DURATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_VOLUME   = 2'd1;

    localparam logic [12:0] NOTE_DURATION_RST = 13'd100;
    localparam logic [3:0]  NOTE_VOLUME_RST   = 4'd3;
    localparam logic [3:0]  VOL_MAX           = 4'd10;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  tone;
        logic [12:0] duration_ms;
        logic [3:0]  volume;
        logic [3:0]  melody;
    } btmp_in_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic finished;
    } btmp_out_t;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_DECODE,
        DP_NEXT,
        DP_LOAD,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tone;
        logic is_melody;
        logic tick_next;
        logic has_note;
        logic div_busy;
        logic div_done;
        logic count_zero;
        logic melody_active;
        logic out_free;
    } dp_sts_t;

    // number of playable notes in a row
    function automatic logic [4:0] row_length(input logic [3:0] row);
        logic [4:0] len;
        unique case (row)
            4'd0, 4'd1, 4'd2: len = 5'd2;
            4'd3, 4'd4, 4'd5: len = 5'd4;
            4'd6, 4'd7, 4'd8: len = 5'd7;
            4'd9:             len = 5'd6;
            4'd10:            len = 5'd5;
            default:          len = 5'd0;
        endcase
        if ({1'b0, row} >= 5'(MELODY_ROWS)) begin
            len = 5'd0;
        end
        if (len > 5'(NOTES_PER_ROW)) begin
            len = 5'(NOTES_PER_ROW);
        end
        return len;
    endfunction

    // tone step of one note
    function automatic logic [2:0] rom_tone(input logic [3:0] row, input logic [3:0] pos);
        logic [2:0] t;
        unique case ({row, pos})
            8'h00: t = 3'd1;  8'h01: t = 3'd2;
            8'h10: t = 3'd2;  8'h11: t = 3'd7;
            8'h20: t = 3'd6;  8'h21: t = 3'd1;
            8'h30: t = 3'd3;  8'h31: t = 3'd3;  8'h32: t = 3'd4;  8'h33: t = 3'd5;
            8'h40: t = 3'd5;  8'h41: t = 3'd4;  8'h42: t = 3'd3;  8'h43: t = 3'd2;
            8'h50: t = 3'd7;  8'h51: t = 3'd2;  8'h52: t = 3'd3;  8'h53: t = 3'd1;
            8'h60: t = 3'd5;  8'h61: t = 3'd5;  8'h62: t = 3'd6;  8'h63: t = 3'd4;
            8'h64: t = 3'd3;  8'h65: t = 3'd1;  8'h66: t = 3'd5;
            8'h70: t = 3'd7;  8'h71: t = 3'd7;  8'h72: t = 3'd5;  8'h73: t = 3'd6;
            8'h74: t = 3'd1;  8'h75: t = 3'd2;  8'h76: t = 3'd4;
            8'h80: t = 3'd6;  8'h81: t = 3'd6;  8'h82: t = 3'd2;  8'h83: t = 3'd3;
            8'h84: t = 3'd1;  8'h85: t = 3'd4;  8'h86: t = 3'd7;
            8'h90: t = 3'd1;  8'h91: t = 3'd2;  8'h92: t = 3'd5;  8'h93: t = 3'd6;
            8'h94: t = 3'd3;  8'h95: t = 3'd4;
            8'hA0: t = 3'd1;  8'hA1: t = 3'd2;  8'hA2: t = 3'd1;  8'hA3: t = 3'd2;
            8'hA4: t = 3'd6;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/btmp_div.sv =====
// btmp_div: restoring divider, one quotient bit per cycle, for the note repeat count
// depends on btmp_pkg for widths
`timescale 1ns / 1ps

module btmp_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [btmp_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [btmp_pkg::DIVISOR_W-1:0]     divisor,
    output logic                               busy,
    output logic                               done,
    output logic [btmp_pkg::DIVIDEND_W-1:0]    quotient
);
    import btmp_pkg::*;

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = trial >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/btmp_datapath.sv =====
// btmp_datapath: playback state, config registers, note loading, melody rom and result register
// depends on btmp_pkg and btmp_div
`timescale 1ns / 1ps

module btmp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  btmp_pkg::btmp_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output btmp_pkg::btmp_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [btmp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  btmp_pkg::dp_cmd_t                   cmd,
    output btmp_pkg::dp_sts_t                   sts
);
    import btmp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } phase_t;

    btmp_in_t       item_reg, item_next;
    logic [12:0]    dur_cfg_reg;
    logic [3:0]     vol_cfg_reg;
    phase_t         phase_reg, phase_next;
    logic [15:0]    high_reg, high_next;
    logic [15:0]    low_reg, low_next;
    logic [15:0]    pc_reg, pc_next;
    logic [15:0]    pl_reg, pl_next;
    logic [3:0]     row_reg, row_next;
    logic [3:0]     pos_reg, pos_next;
    logic           mel_reg, mel_next;
    logic [7:0]     tone_reg, tone_next;
    logic [3:0]     vol_reg, vol_next;
    logic           pin_reg, pin_next;
    logic           busy_reg, busy_next;
    logic           fin_reg, fin_next;
    btmp_out_t      out_reg, out_next;
    logic           out_valid_reg, out_valid_next;

    // tick decode
    logic           active;
    logic [15:0]    pc_dec;
    logic [15:0]    pl_dec;
    logic           pc_end;
    logic           to_low;
    logic           more_periods;
    logic           is_tone;
    logic           is_melody;

    // note selection and divider
    logic [4:0]             row_len;
    logic                   has_note;
    logic [2:0]             rom_t;
    logic [12:0]            dur_sel;
    logic [7:0]             tone_sel;
    logic                   div_start;
    logic [DIVIDEND_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]   divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  quotient;

    // note load
    logic [3:0]     vol_sat;
    logic [10:0]    tenth;
    logic [15:0]    high_new;
    logic [15:0]    low_new;
    logic [15:0]    count_sat;
    logic           count_zero;

    always_comb begin
        is_tone      = item_reg.func == FUNC_TONE;
        is_melody    = item_reg.func == FUNC_MELODY;
        active       = (phase_reg == PH_HIGH) || (phase_reg == PH_LOW);
        pc_dec       = (pc_reg == 16'd0) ? 16'd0 : pc_reg - 16'd1;
        pl_dec       = (pl_reg == 16'd0) ? 16'd0 : pl_reg - 16'd1;
        pc_end       = pc_dec == 16'd0;
        to_low       = (phase_reg == PH_HIGH) && (low_reg != 16'd0);
        more_periods = pl_dec != 16'd0;

        row_len  = row_length(row_reg);
        has_note = {1'b0, pos_reg} < row_len;
        rom_t    = rom_tone(row_reg, pos_reg);

        dur_sel   = (cmd.op == DP_DECODE) ? item_reg.duration_ms : dur_cfg_reg;
        tone_sel  = (cmd.op == DP_DECODE) ? item_reg.tone : {5'd0, rom_t};
        div_start = ((cmd.op == DP_DECODE) && is_tone) || ((cmd.op == DP_NEXT) && has_note);
        dividend  = {10'd0, dur_sel} * 23'd1000;
        divisor   = {6'd0, tone_sel} * 14'd50 + 14'd100;

        // period / 10 is exactly tone*5 + 10
        vol_sat    = (vol_reg > VOL_MAX) ? VOL_MAX : vol_reg;
        tenth      = {3'd0, tone_reg} * 11'd5 + 11'd10;
        high_new   = {5'd0, tenth} * {12'd0, vol_sat};
        low_new    = {5'd0, tenth} * {12'd0, VOL_MAX - vol_sat};
        count_sat  = (|quotient[DIVIDEND_W-1:COUNT_W]) ? 16'hFFFF : quotient[COUNT_W-1:0];
        count_zero = quotient == '0;
    end

    btmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        item_next      = item_reg;
        phase_next     = phase_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        pc_next        = pc_reg;
        pl_next        = pl_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        mel_next       = mel_reg;
        tone_next      = tone_reg;
        vol_next       = vol_reg;
        pin_next       = pin_reg;
        busy_next      = busy_reg;
        fin_next       = fin_reg;
        out_next       = out_reg;
        out_valid_next = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;

        if (cmd.capture) begin
            item_next = s_data;
        end

        unique case (cmd.op)
            DP_DECODE: begin
                pin_next  = 1'b0;
                busy_next = 1'b0;
                fin_next  = 1'b0;
                if (is_tone) begin
                    mel_next  = 1'b0;
                    tone_next = item_reg.tone;
                    vol_next  = item_reg.volume;
                end else if (is_melody) begin
                    row_next = item_reg.melody;
                    pos_next = 4'd0;
                    mel_next = 1'b1;
                end else if (active) begin
                    pin_next  = phase_reg == PH_HIGH;
                    busy_next = 1'b1;
                    if (!pc_end) begin
                        pc_next = pc_dec;
                    end else if (to_low) begin
                        phase_next = PH_LOW;
                        pc_next    = low_reg;
                    end else begin
                        pl_next = pl_dec;
                        if (more_periods) begin
                            phase_next = (high_reg != 16'd0) ? PH_HIGH : PH_LOW;
                            pc_next    = (high_reg != 16'd0) ? high_reg : low_reg;
                        end else if (!mel_reg) begin
                            phase_next = PH_IDLE;
                            pc_next    = 16'd0;
                            fin_next   = 1'b1;
                        end
                    end
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            DP_NEXT: begin
                if (has_note) begin
                    tone_next = {5'd0, rom_t};
                    vol_next  = vol_cfg_reg;
                    pos_next  = pos_reg + 4'd1;
                end else begin
                    phase_next = PH_IDLE;
                    pc_next    = 16'd0;
                    mel_next   = 1'b0;
                    fin_next   = 1'b1;
                end
            end
            DP_LOAD: begin
                if (!count_zero) begin
                    high_next  = high_new;
                    low_next   = low_new;
                    pl_next    = count_sat;
                    phase_next = (high_new != 16'd0) ? PH_HIGH : PH_LOW;
                    pc_next    = (high_new != 16'd0) ? high_new : low_new;
                    busy_next  = 1'b1;
                end else if (!mel_reg) begin
                    // empty single tone ends at once
                    phase_next = PH_IDLE;
                    pc_next    = 16'd0;
                    fin_next   = 1'b1;
                end
            end
            DP_EMIT: begin
                out_next.pin_level = pin_reg;
                out_next.busy_res  = busy_reg;
                out_next.finished  = fin_reg;
                out_valid_next     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_cfg_reg   <= NOTE_DURATION_RST;
            vol_cfg_reg   <= NOTE_VOLUME_RST;
            phase_reg     <= PH_IDLE;
            high_reg      <= '0;
            low_reg       <= '0;
            pc_reg        <= '0;
            pl_reg        <= '0;
            row_reg       <= '0;
            pos_reg       <= '0;
            mel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_NOTE_DURATION: dur_cfg_reg <= cfg_data;
                    REG_NOTE_VOLUME:   vol_cfg_reg <= cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            phase_reg     <= phase_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            pc_reg        <= pc_next;
            pl_reg        <= pl_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
            mel_reg       <= mel_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg <= item_next;
        tone_reg <= tone_next;
        vol_reg  <= vol_next;
        pin_reg  <= pin_next;
        busy_reg <= busy_next;
        fin_reg  <= fin_next;
        out_reg  <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        sts.is_tone       = is_tone;
        sts.is_melody     = is_melody;
        sts.tick_next     = active && pc_end && !to_low && !more_periods && mel_reg;
        sts.has_note      = has_note;
        sts.div_busy      = div_busy;
        sts.div_done      = div_done;
        sts.count_zero    = count_zero;
        sts.melody_active = mel_reg;
        sts.out_free      = !out_valid_reg || m_ready;
    end

endmodule

// ===== rtl/core/btmp_ctrl.sv =====
// btmp_ctrl: sequencer that steps the datapath through decode, note search, divide, load and emit
// depends on btmp_pkg
`timescale 1ns / 1ps

module btmp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  btmp_pkg::dp_sts_t   sts,
    output btmp_pkg::dp_cmd_t   cmd
);
    import btmp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_NEXT,
        ST_DIV,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.op      = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.op = DP_DECODE;
                priority if (sts.is_tone) begin
                    state_next = ST_DIV;
                end else if (sts.is_melody || sts.tick_next) begin
                    state_next = ST_NEXT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_NEXT: begin
                cmd.op     = DP_NEXT;
                state_next = sts.has_note ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.op     = DP_LOAD;
                state_next = (sts.count_zero && sts.melody_active) ? ST_NEXT : ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.op     = DP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

endmodule

// ===== rtl/core/buzzer_tone_melody_player_top.sv =====
// buzzer_tone_melody_player_top: top level of the buzzer tone and melody player
// depends on btmp_pkg, btmp_ctrl and btmp_datapath
`timescale 1ns / 1ps

// Plays tones and melodies on a buzzer pin, stepped by input items that are either one-microsecond
// ticks or start commands; every item gives exactly one result item carrying the pin level, a busy
// flag and a finished pulse. A tone command sets period = tone*50+100 us and a repeat count of
// duration_ms*1000/period (held at 65535), with the high share of each period set by volume in
// tenths. A melody command walks one row of a built-in note table using the note_duration_ms and
// note_volume registers, and any new command cuts off what is playing. Items are handled one at a
// time: a tick that stays inside a note passes only the decode and emit states, and every note
// start (a tone command, a melody command, or the tick that closes a melody note) also waits,
// once per note tried, for the repeat count from a 23-step divider that yields one quotient bit
// per cycle; notes whose count is zero are skipped, each still passing through the divider. The
// finished result waits in an output register, so a stalled consumer only holds up the next item
// at the moment it must hand its own result over. Configuration writes are taken in every cycle
// and must only be made while the block is idle.

module buzzer_tone_melody_player_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  btmp_pkg::btmp_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output btmp_pkg::btmp_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btmp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [btmp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import btmp_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencer: one item in flight, owns the input handshake
    btmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: playback counters, divider, note table, config and output register
    btmp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // the divider only runs for an item already taken in
    assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_busy |-> !s_ready)
    else $error("divider running while input is ready");

    // an accepted item closes the input until its result is out
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
    else $error("input stayed open after accepting an item");

    // the pin is only driven high while something is playing
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.busy_res || !m_data.pin_level))
    else $error("pin high in a result that is not busy");

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for buzzer_tone_melody_player_top
// depends on btmp_pkg and the rtl under rtl/core; the class below predicts each result item
`timescale 1ns / 1ps

module tb_top;

    import btmp_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 60;
    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int PHASE_ITEMS   = 30;
    localparam int IN_W          = $bits(btmp_in_t);

    // func code 3 is not defined, the block handles it as a tick
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    // register index with nothing behind it, writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW
    } play_phase_t;

    // notes per melody row and the tone step of every note
    localparam int ROW_NOTES [0:15] = '{2, 2, 2, 4, 4, 4, 7, 7, 7, 6, 5, 0, 0, 0, 0, 0};
    localparam logic [2:0] MELODY_TONES [0:10][0:6] = '{
        '{1, 2, 0, 0, 0, 0, 0},
        '{2, 7, 0, 0, 0, 0, 0},
        '{6, 1, 0, 0, 0, 0, 0},
        '{3, 3, 4, 5, 0, 0, 0},
        '{5, 4, 3, 2, 0, 0, 0},
        '{7, 2, 3, 1, 0, 0, 0},
        '{5, 5, 6, 4, 3, 1, 5},
        '{7, 7, 5, 6, 1, 2, 4},
        '{6, 6, 2, 3, 1, 4, 7},
        '{1, 2, 5, 6, 3, 4, 0},
        '{1, 2, 1, 2, 6, 0, 0}
    };

    // tracks the player state, predicts one result per accepted item and checks results
    class buzzer_scoreboard;
        logic [12:0]  note_ms;
        logic [3:0]   note_vol;
        play_phase_t  phase;
        logic [15:0]  high_len;
        logic [15:0]  low_len;
        logic [15:0]  phase_left;
        logic [15:0]  periods_left;
        logic [3:0]   row;
        logic [3:0]   pos;
        logic         melody_on;
        btmp_out_t    expected_levels [$];
        int unsigned  mismatches;
        int unsigned  checked;
        int unsigned  endings;

        function new();
            note_ms      = NOTE_DURATION_RST;
            note_vol     = NOTE_VOLUME_RST;
            phase        = PH_IDLE;
            high_len     = '0;
            low_len      = '0;
            phase_left   = '0;
            periods_left = '0;
            row          = '0;
            pos          = '0;
            melody_on    = 1'b0;
            mismatches   = 0;
            checked      = 0;
            endings      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_NOTE_DURATION) begin
                note_ms = val;
            end else if (idx == REG_NOTE_VOLUME) begin
                note_vol = val[3:0];
            end
        endfunction

        function void open_period();
            if (high_len > 0) begin
                phase      = PH_HIGH;
                phase_left = high_len;
            end else begin
                phase      = PH_LOW;
                phase_left = low_len;
            end
        endfunction

        // loads one note, returns 0 when it has no whole period
        function bit start_note(logic [7:0] tn, logic [12:0] dur, logic [3:0] vol);
            int unsigned period;
            int unsigned count;
            int unsigned tenth;
            int unsigned v;
            period = 50 * int'(tn) + 100;
            count  = (1000 * int'(dur)) / period;
            tenth  = period / 10;
            v      = (vol > 10) ? 10 : int'(vol);
            if (count > 65535) count = 65535;
            if (count == 0) return 1'b0;
            high_len     = 16'(tenth * v);
            low_len      = 16'(tenth * (10 - v));
            periods_left = 16'(count);
            open_period();
            return 1'b1;
        endfunction

        function int unsigned notes_in_row();
            int unsigned n;
            if (row >= MELODY_ROWS) return 0;
            n = ROW_NOTES[row];
            if (n > NOTES_PER_ROW) n = NOTES_PER_ROW;
            return n;
        endfunction

        // skips empty notes, returns 0 at the end of the row
        function bit next_melody_note();
            int unsigned n;
            logic [2:0]  tn;
            n = notes_in_row();
            while (pos < n) begin
                tn  = MELODY_TONES[row][pos];
                pos = pos + 4'd1;
                if (start_note(8'(tn), note_ms, note_vol)) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void go_quiet();
            phase      = PH_IDLE;
            phase_left = '0;
            melody_on  = 1'b0;
        endfunction

        function btmp_out_t advance_playback(btmp_in_t it);
            btmp_out_t r;
            bit        playing;
            r = '0;
            if (it.func == FUNC_TONE || it.func == FUNC_MELODY) begin
                if (it.func == FUNC_TONE) begin
                    melody_on = 1'b0;
                    playing   = start_note(it.tone, it.duration_ms, it.volume);
                end else begin
                    row       = it.melody;
                    pos       = '0;
                    melody_on = 1'b1;
                    playing   = next_melody_note();
                end
                if (playing) begin
                    r.busy_res = 1'b1;
                end else begin
                    go_quiet();
                    r.finished = 1'b1;
                end
            end else if (phase == PH_HIGH || phase == PH_LOW) begin
                r.pin_level = (phase == PH_HIGH);
                r.busy_res  = 1'b1;
                if (phase_left > 0) phase_left = phase_left - 16'd1;
                if (phase_left == 0) begin
                    if (phase == PH_HIGH && low_len > 0) begin
                        phase      = PH_LOW;
                        phase_left = low_len;
                    end else begin
                        if (periods_left > 0) periods_left = periods_left - 16'd1;
                        if (periods_left > 0) begin
                            open_period();
                        end else if (!(melody_on && next_melody_note())) begin
                            go_quiet();
                            r.finished = 1'b1;
                        end
                    end
                end
            end else begin
                phase = PH_IDLE;
            end
            if (r.finished) endings++;
            return r;
        endfunction

        function void note_item(btmp_in_t it);
            expected_levels.push_back(advance_playback(it));
        endfunction

        function void flag(string field, logic want, logic got);
            $display("%0t %s mismatch on result %0d: expected %b, got %b",
                     $time, field, checked, want, got);
            mismatches++;
        endfunction

        function void check_item(btmp_out_t got);
            btmp_out_t want;
            if (expected_levels.size() == 0) begin
                $display("%0t result item %b arrived with nothing outstanding", $time, got);
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            checked++;
            if (got.pin_level !== want.pin_level) flag("pin_level", want.pin_level, got.pin_level);
            if (got.busy_res !== want.busy_res) flag("busy_res", want.busy_res, got.busy_res);
            if (got.finished !== want.finished) flag("finished", want.finished, got.finished);
        endfunction

        function int outstanding();
            return expected_levels.size();
        endfunction

        function bit is_quiet();
            return phase == PH_IDLE;
        endfunction

        function void report_leftovers();
            if (expected_levels.size() != 0) begin
                $display("%0t %0d expected results never arrived",
                         $time, expected_levels.size());
                mismatches += expected_levels.size();
            end
        endfunction
    endclass

    // every input known from time zero, reset held low from the start
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    btmp_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    btmp_out_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    buzzer_scoreboard sb;

    // pacing knobs shared between the stimulus and the result sink
    bit          sender_calm   = 1'b0;
    bit          sink_calm     = 1'b0;
    int          sink_hold_len = 0;
    int          longest_hold  = 0;
    int unsigned items_sent    = 0;
    int unsigned cfg_writes    = 0;
    int unsigned settings_used = 1;
    int unsigned playouts      = 0;
    int unsigned quiet_cycles  = 0;

    buzzer_tone_melody_player_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog: ends the run when no channel has moved an item for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: %0d cycles without any handshake", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // fully random item, callers overwrite the fields that matter
    function automatic btmp_in_t scramble();
        logic [IN_W-1:0] raw;
        raw = IN_W'($urandom);
        return raw;
    endfunction

    // one microsecond tick, now and then with the undefined func code
    function automatic btmp_in_t tick_item();
        btmp_in_t it;
        it      = scramble();
        it.func = ($urandom_range(0, 7) == 0) ? FUNC_SPARE : FUNC_TICK;
        return it;
    endfunction

    function automatic btmp_in_t make_tone(logic [7:0] tn, logic [12:0] dur, logic [3:0] vol);
        btmp_in_t it;
        it             = scramble();
        it.func        = FUNC_TONE;
        it.tone        = tn;
        it.duration_ms = dur;
        it.volume      = vol;
        return it;
    endfunction

    function automatic btmp_in_t make_melody(logic [3:0] r);
        btmp_in_t it;
        it        = scramble();
        it.func   = FUNC_MELODY;
        it.melody = r;
        return it;
    endfunction

    // offers one item after a random gap; valid stays up when the gap is zero
    task automatic send_item(input btmp_in_t it);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    // lowers valid at the accepting edge and waits for every outstanding result
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // an empty tone ends any playback at once, after which the block is idle
    task automatic quiesce();
        send_item(make_tone(8'($urandom), 13'd0, 4'($urandom)));
        drain_results();
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
        cfg_writes++;
    endtask

    // random commands, each followed by a burst of ticks; long bursts let
    // periods and notes roll over, short ones make the next command cut in
    task automatic random_items(input int budget);
        int unsigned first;
        int          ticks;
        logic [7:0]  tn;
        logic [12:0] dur;
        btmp_in_t    it;
        first = items_sent;
        while (items_sent - first < budget) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            sink_calm   = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    it = tick_item();
                end
                1, 2, 3, 4: begin
                    tn = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    case ($urandom_range(0, 9))
                        0, 1:          dur = 13'd0;
                        2, 3, 4, 5, 6: dur = 13'($urandom_range(1, 5));
                        default:       dur = 13'($urandom);
                    endcase
                    it = make_tone(tn, dur, 4'($urandom));
                end
                default: begin
                    it = make_melody(($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                                 : 4'($urandom_range(0, 10)));
                end
            endcase
            send_item(it);
            ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                                : $urandom_range(0, 20);
            repeat (ticks) send_item(tick_item());
            // now and then the sender waits for every result before going on
            if ($urandom_range(0, 15) == 0) drain_results();
        end
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
    endtask

    // stop playback, load both registers, then run random items
    task automatic run_phase(input logic [12:0] ms, input logic [3:0] vol, input int budget);
        quiesce();
        write_reg(REG_NOTE_DURATION, ms);
        write_reg(REG_NOTE_VOLUME, {9'($urandom), vol});
        settings_used++;
        random_items(budget);
    endtask

    // ticks until the predicted playback ends on its own
    task automatic play_out(input btmp_in_t cmd);
        send_item(cmd);
        while (!sb.is_quiet()) send_item(tick_item());
        playouts++;
    endtask

    // result sink: random hold-off per result item, or one long hold when asked
    initial begin : result_sink
        int hold;
        wait (aresetn === 1'b1);
        forever begin
            if (sink_hold_len > 0) begin
                hold          = sink_hold_len;
                sink_hold_len = 0;
                longest_hold  = hold;
            end else begin
                hold = sink_calm ? 0 : $urandom_range(0, 16);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_item(m_data);
        end
    end

    initial begin : stimulus
        btmp_in_t it;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset register values
        // ticks while idle, plain and with the undefined func code
        it      = tick_item();
        it.func = FUNC_TICK;
        send_item(it);
        it.func = FUNC_SPARE;
        send_item(it);
        // zero duration, and a period too long for one millisecond: both end at once
        send_item(make_tone(8'd0, 13'd0, 4'd5));
        send_item(make_tone(8'd255, 13'd1, 4'd5));
        // repeat count saturates and volume above ten saturates
        send_item(make_tone(8'd0, 13'd8191, 4'd15));
        send_item(tick_item());
        it.func = FUNC_SPARE;
        send_item(it);
        send_item(tick_item());
        // volume zero: high phase empty, cuts the tone above
        send_item(make_tone(8'd18, 13'd1, 4'd0));
        send_item(tick_item());
        send_item(tick_item());
        // volume ten: low phase empty
        send_item(make_tone(8'd0, 13'd2, 4'd10));
        send_item(tick_item());
        // widest tone at volume ten with a long duration
        send_item(make_tone(8'd255, 13'd6553, 4'd10));
        send_item(tick_item());
        // rows without notes and row 15 end at once
        send_item(make_melody(4'd11));
        send_item(make_melody(4'd15));
        send_item(make_melody(4'd14));
        // melodies cutting one another
        send_item(make_melody(4'd10));
        send_item(tick_item());
        send_item(tick_item());
        send_item(make_melody(4'd0));
        send_item(tick_item());

        random_items(PHASE_ITEMS);

        // zero note length: every melody note is empty
        run_phase(13'd0, 4'd0, PHASE_ITEMS);

        // one millisecond notes; a single-period tone is played to its end
        run_phase(13'd1, 4'd10, PHASE_ITEMS);
        play_out(make_tone(8'd9, 13'd1, 4'($urandom)));
        // the first melody note plays whole, then zero note length leaves the rest
        // of the row empty, so the row ends on the tick that closes that note
        send_item(make_melody(4'd4));
        drain_results();
        write_reg(REG_NOTE_DURATION, 13'd0);
        play_out(tick_item());

        // long notes, volume register above ten
        run_phase(13'd6553, 4'd15, PHASE_ITEMS);

        // back-pressure: the sink holds off while the sender keeps offering ticks,
        // so the block fills and must stall its input
        sender_calm   = 1'b1;
        sink_hold_len = LONG_HOLD;
        send_item(make_tone(8'd0, 13'd5, 4'd5));
        repeat (30) send_item(tick_item());
        sender_calm = 1'b0;
        drain_results();

        // widest duration register value, then a write to an unused index
        run_phase(13'd8191, 4'd7, PHASE_ITEMS);
        quiesce();
        write_reg(REG_SPARE, 13'($urandom));

        // a couple of random settings, mostly short notes
        repeat (2) begin
            run_phase(($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4)),
                      4'($urandom), PHASE_ITEMS);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        sb.report_leftovers();

        $display("covered %0d items over %0d register settings (%0d writes), %0d results compared",
                 items_sent, settings_used, cfg_writes, sb.checked);
        $display("%0d playback ends, %0d played to completion, longest sink hold-off %0d cycles",
                 sb.endings, playouts, longest_hold);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
